// ===== rtl/core/rtul_pkg.sv =====
// Shared constants and types for the routing table update and lookup block.
package rtul_pkg;

    // Default table size; one entry is the implicit self route.
    localparam int TABLE_ENTRIES_DEF = 8;

    // Configuration port geometry.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 64;

    // Register select, taken from the 8-byte word address bit.
    localparam logic REG_OWN_ADDR = 1'b0;
    localparam logic REG_HYST     = 1'b1;

    // Reset value of the metric hysteresis register.
    localparam logic [7:0] HYST_RESET = 8'd5;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_UPDATED   = 3'd3,
        ST_UNCHANGED = 3'd4,
        ST_FULL      = 3'd5,
        ST_OWN       = 3'd6
    } status_t;

    // Request types.
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

endpackage

// ===== rtl/core/rtul_if.sv =====
// Request and response channel interfaces of the routing table block.
interface rtul_req_if;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [63:0]       dest_addr;
    logic [7:0]        report_hops;
    logic signed [7:0] link_metric;
    logic [15:0]       report_seq;

    modport source (output valid, req_type, dest_addr, report_hops, link_metric, report_seq,
                    input ready);
    modport sink   (input valid, req_type, dest_addr, report_hops, link_metric, report_seq,
                    output ready);
endinterface

interface rtul_rsp_if;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [63:0]       next_hop_addr;
    logic [7:0]        route_hops;
    logic signed [7:0] route_metric;
    logic [15:0]       route_seq;

    modport source (output valid, status, next_hop_addr, route_hops, route_metric, route_seq,
                    input ready);
    modport sink   (input valid, status, next_hop_addr, route_hops, route_metric, route_seq,
                    output ready);
endinterface

// ===== rtl/core/route_table_update_lookup.sv =====
// Top level of the routing table: update reports, route lookups and config registers.
//
//   Channel | Direction | Handshake    | Carries
//   --------+-----------+--------------+-------------------------------------------
//   req     | in        | valid/ready  | request type, destination, hops, metric, seq
//   rsp     | out       | valid/ready  | status, next hop, hops, metric, seq
//   apb     | in        | psel/penable | own address (0x0), metric hysteresis (0x8)
//
// One request per cycle while the response is not stalled: a request is held in the
// input register, where all table slots are compared in parallel, and is then written
// to the result register.
// The table is updated at the same edge the response is registered, so the next
// request always sees the effect of the previous one.
// Reset clears all slot valid bits, the own address and sets the hysteresis to 5.
// A stalled response holds the result register; one more request still enters the
// input register before req.ready drops.
module route_table_update_lookup #(
    parameter int TABLE_ENTRIES = rtul_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rtul_pkg::ADDR_W-1:0] paddr,
    input  logic [rtul_pkg::DATA_W-1:0] pwdata,
    output logic [rtul_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    rtul_req_if.sink                   req,
    rtul_rsp_if.source                 rsp
);

    localparam int SlotCount = TABLE_ENTRIES - 1;

    // Configuration registers.
    logic [63:0] own_addr_reg;
    logic [7:0]  hyst_reg;

    // Input register.
    logic              in_valid_reg;
    logic              in_type_reg;
    logic [63:0]       in_dest_reg;
    logic [7:0]        in_hops_reg;
    logic signed [7:0] in_metric_reg;
    logic [15:0]       in_seq_reg;

    // Result register.
    logic                  out_valid_reg;
    rtul_pkg::status_t     out_status_reg;
    logic [63:0]           out_nh_reg;
    logic [7:0]            out_hops_reg;
    logic signed [7:0]     out_metric_reg;
    logic [15:0]           out_seq_reg;

    // Table slots.
    logic [SlotCount-1:0]     slot_valid_reg;
    logic [63:0]              slot_dest_reg   [SlotCount];
    logic [7:0]               slot_hops_reg   [SlotCount];
    logic signed [7:0]        slot_metric_reg [SlotCount];
    logic [15:0]              slot_seq_reg    [SlotCount];

    logic                  accept;
    logic                  advance;
    logic                  cfg_write;
    logic [SlotCount-1:0]  match;
    logic [SlotCount-1:0]  free;
    logic [SlotCount-1:0]  free_first;
    logic [SlotCount-1:0]  ins_sel;
    logic [SlotCount-1:0]  upd_sel;
    logic                  own_hit;
    logic                  found;
    logic [7:0]            rd_hops;
    logic [7:0]            rd_metric;
    logic [15:0]           rd_seq;
    logic signed [8:0]     metric_diff;
    logic [8:0]            metric_abs;
    logic                  upd_ok;
    rtul_pkg::status_t     status_next;
    logic [63:0]           nh_next;
    logic [7:0]            hops_next;
    logic [7:0]            metric_next;
    logic [15:0]           seq_next;

    // Handshake control.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[3] == rtul_pkg::REG_HYST) ? {56'd0, hyst_reg} : own_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= '0;
            hyst_reg     <= rtul_pkg::HYST_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == rtul_pkg::REG_HYST)
            begin
                hyst_reg <= pwdata[7:0];
            end
            else
            begin
                own_addr_reg <= pwdata;
            end
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_type_reg   <= req.req_type;
            in_dest_reg   <= req.dest_addr;
            in_hops_reg   <= req.report_hops;
            in_metric_reg <= req.link_metric;
            in_seq_reg    <= req.report_seq;
        end
    end

    // Parallel compare against every slot and one-hot read of the matching one.
    always_comb
    begin
        rd_hops   = '0;
        rd_metric = '0;
        rd_seq    = '0;
        for (int i = 0; i < SlotCount; i++)
        begin
            match[i] = slot_valid_reg[i] && (slot_dest_reg[i] == in_dest_reg);
            rd_hops   = rd_hops   | (slot_hops_reg[i] & {8{match[i]}});
            rd_metric = rd_metric | (slot_metric_reg[i] & {8{match[i]}});
            rd_seq    = rd_seq    | (slot_seq_reg[i] & {16{match[i]}});
        end
    end

    assign own_hit    = (in_dest_reg == own_addr_reg);
    assign found      = |match;
    assign free       = ~slot_valid_reg;
    assign free_first = free & (~free + SlotCount'(1));

    // Metric difference and replacement condition.
    assign metric_diff = $signed({rd_metric[7], rd_metric})
                       - $signed({in_metric_reg[7], in_metric_reg});
    assign metric_abs  = metric_diff[8] ? 9'(-metric_diff) : 9'(metric_diff);
    assign upd_ok      = (rd_seq < in_seq_reg) && (metric_abs > {1'b0, hyst_reg});

    // Request decision.
    always_comb
    begin
        status_next = rtul_pkg::ST_MISS;
        nh_next     = '0;
        hops_next   = '0;
        metric_next = '0;
        seq_next    = '0;
        ins_sel     = '0;
        upd_sel     = '0;
        if (in_type_reg == rtul_pkg::REQ_LOOKUP)
        begin
            if (own_hit)
            begin
                status_next = rtul_pkg::ST_HIT;
                nh_next     = own_addr_reg;
            end
            else if (found)
            begin
                status_next = rtul_pkg::ST_HIT;
                nh_next     = in_dest_reg;
                hops_next   = rd_hops;
                metric_next = rd_metric;
                seq_next    = rd_seq;
            end
        end
        else
        begin
            if (own_hit)
            begin
                status_next = rtul_pkg::ST_OWN;
            end
            else if (found)
            begin
                if (upd_ok)
                begin
                    status_next = rtul_pkg::ST_UPDATED;
                    upd_sel     = match;
                end
                else
                begin
                    status_next = rtul_pkg::ST_UNCHANGED;
                end
            end
            else if (|free)
            begin
                status_next = rtul_pkg::ST_INSERTED;
                ins_sel     = free_first;
            end
            else
            begin
                status_next = rtul_pkg::ST_FULL;
            end
        end
    end

    // Slot valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (advance)
        begin
            slot_valid_reg <= slot_valid_reg | ins_sel;
        end
    end

    // Slot contents.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < SlotCount; i++)
            begin
                if (ins_sel[i])
                begin
                    slot_dest_reg[i]   <= in_dest_reg;
                    slot_hops_reg[i]   <= in_hops_reg;
                    slot_metric_reg[i] <= in_metric_reg;
                    slot_seq_reg[i]    <= in_seq_reg;
                end
                else if (upd_sel[i])
                begin
                    slot_metric_reg[i] <= in_metric_reg;
                end
            end
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= status_next;
            out_nh_reg     <= nh_next;
            out_hops_reg   <= hops_next;
            out_metric_reg <= metric_next;
            out_seq_reg    <= seq_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.next_hop_addr = out_nh_reg;
    assign rsp.route_hops    = out_hops_reg;
    assign rsp.route_metric  = out_metric_reg;
    assign rsp.route_seq     = out_seq_reg;

endmodule

// ===== rtl/core/rtul_checker.sv =====
// Port-level checker for the routing table block and its bind statement.
module rtul_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [2:0]        rsp_status,
    input logic [63:0]       rsp_next_hop_addr,
    input logic [7:0]        rsp_route_hops,
    input logic signed [7:0] rsp_route_metric,
    input logic [15:0]       rsp_route_seq
);

    // A stalled response keeps its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
        else $error("stalled response changed");

    // Any result other than a hit carries an all-zero route.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != rtul_pkg::ST_HIT) |->
            (rsp_next_hop_addr == '0) && (rsp_route_hops == '0) &&
            (rsp_route_metric == '0) && (rsp_route_seq == '0))
        else $error("non-hit response carries route data");

    // With no response pending, the request side is always open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request blocked with empty output");

    // A request accepted into an empty block shows a response after the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid && $past(req_ready) && !$past(req_valid)
            |-> ##2 rsp_valid)
        else $error("response missing after request");

endmodule

bind route_table_update_lookup rtul_checker u_rtul_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_next_hop_addr (rsp.next_hop_addr),
    .rsp_route_hops    (rsp.route_hops),
    .rsp_route_metric  (rsp.route_metric),
    .rsp_route_seq     (rsp.route_seq)
);

// ===== tb/tb_route_table_update_lookup.sv =====
// Self-checking testbench for the routing table: update reports, lookups and register writes.
module tb_route_table_update_lookup;

    localparam int SLOTS = rtul_pkg::TABLE_ENTRIES_DEF - 1;

    typedef struct packed {
        logic        req_type;
        logic [63:0] dest_addr;
        logic [7:0]  report_hops;
        logic [7:0]  link_metric;
        logic [15:0] report_seq;
    } route_req_t;

    typedef struct packed {
        rtul_pkg::status_t status;
        logic [63:0]       next_hop_addr;
        logic [7:0]        route_hops;
        logic [7:0]        route_metric;
        logic [15:0]       route_seq;
    } route_reply_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [rtul_pkg::ADDR_W-1:0] paddr;
    logic [rtul_pkg::DATA_W-1:0] pwdata;
    logic [rtul_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    rtul_req_if req_bus ();
    rtul_rsp_if rsp_bus ();

    // Shadow copy of the table and the registers; the table is advanced on every accepted request.
    logic [63:0] node_addr;
    logic [7:0]  hyst_level;
    logic        known_used   [SLOTS];
    logic [63:0] known_dest   [SLOTS];
    logic [7:0]  known_hops   [SLOTS];
    logic [7:0]  known_metric [SLOTS];
    logic [15:0] known_seq    [SLOTS];

    // Replies owed by the block, oldest first.
    route_reply_t route_replies [$];

    int          errors;
    int          requests_sent;
    int          replies_checked;
    int          status_seen [8];

    // Receiver behavior: a repeating stall mask and an optional long hold-off.
    logic [15:0] stall_mask;
    int          hold_off_left;

    route_table_update_lookup u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_bus),
        .rsp     (rsp_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    // Find the slot that holds a destination, or -1.
    function automatic int find_known(input logic [63:0] dest);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (known_used[i] && known_dest[i] == dest)
                return i;
        end
        return -1;
    endfunction

    // Work out the reply to one request and apply its effect on the table.
    function automatic route_reply_t apply_route_request(input route_req_t r);
        route_reply_t a;
        int           idx;
        int           gap;
        a = '0;
        idx = find_known(r.dest_addr);
        if (r.req_type == rtul_pkg::REQ_LOOKUP)
        begin
            if (r.dest_addr == node_addr)
            begin
                a.status = rtul_pkg::ST_HIT;
                a.next_hop_addr = node_addr;
            end
            else if (idx >= 0)
            begin
                a.status = rtul_pkg::ST_HIT;
                a.next_hop_addr = known_dest[idx];
                a.route_hops = known_hops[idx];
                a.route_metric = known_metric[idx];
                a.route_seq = known_seq[idx];
            end
            else
                a.status = rtul_pkg::ST_MISS;
        end
        else if (r.dest_addr == node_addr)
            a.status = rtul_pkg::ST_OWN;
        else if (idx >= 0)
        begin
            gap = int'($signed(known_metric[idx])) - int'($signed(r.link_metric));
            if (gap < 0)
                gap = -gap;
            if (known_seq[idx] < r.report_seq && gap > int'(hyst_level))
            begin
                known_metric[idx] = r.link_metric;
                a.status = rtul_pkg::ST_UPDATED;
            end
            else
                a.status = rtul_pkg::ST_UNCHANGED;
        end
        else
        begin
            a.status = rtul_pkg::ST_FULL;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!known_used[i])
                begin
                    known_used[i] = 1'b1;
                    known_dest[i] = r.dest_addr;
                    known_hops[i] = r.report_hops;
                    known_metric[i] = r.link_metric;
                    known_seq[i] = r.report_seq;
                    a.status = rtul_pkg::ST_INSERTED;
                    break;
                end
            end
        end
        return a;
    endfunction

    // Random request, biased toward stored routes, the own address and the hysteresis edge.
    function automatic route_req_t make_random_request();
        route_req_t r;
        int         pick;
        int         slot;
        int         step;
        int         target;
        r.req_type = 1'($urandom_range(0, 1));
        r.dest_addr = {$urandom, $urandom};
        r.report_hops = 8'($urandom_range(0, 255));
        r.link_metric = 8'($urandom_range(0, 255));
        r.report_seq = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, SLOTS - 1);
        if (pick < 65 && known_used[slot])
        begin
            r.dest_addr = known_dest[slot];
            r.req_type = (pick < 45) ? rtul_pkg::REQ_UPDATE : rtul_pkg::REQ_LOOKUP;
            if (pick < 25)
            begin
                step = int'(hyst_level) + int'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1)
                    step = -step;
                target = int'($signed(known_metric[slot])) + step;
                if (target >= -128 && target <= 127)
                    r.link_metric = 8'(target);
            end
        end
        else if (pick < 75)
            r.dest_addr = node_addr;
        return r;
    endfunction

    // Offer one request and wait for it to be taken; called on a clock edge.
    task automatic send_request(input route_req_t r);
        req_bus.valid <= 1'b1;
        req_bus.req_type <= r.req_type;
        req_bus.dest_addr <= r.dest_addr;
        req_bus.report_hops <= r.report_hops;
        req_bus.link_metric <= r.link_metric;
        req_bus.report_seq <= r.report_seq;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        route_replies.push_back(apply_route_request(r));
        requests_sent++;
    endtask

    task automatic issue_request(input logic kind, input logic [63:0] dest, input int hops,
                                 input int metric, input int seq);
        route_req_t r;
        r.req_type = kind;
        r.dest_addr = dest;
        r.report_hops = 8'(hops);
        r.link_metric = 8'(metric);
        r.report_seq = 16'(seq);
        send_request(r);
    endtask

    // Drop valid and wait until every owed reply has been seen.
    task automatic settle();
        req_bus.valid <= 1'b0;
        while (route_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register, then read it back.
    task automatic write_register(input logic regsel, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {regsel, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (regsel == rtul_pkg::REG_OWN_ADDR)
            node_addr = value;
        else
            hyst_level = value[7:0];
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if ((regsel == rtul_pkg::REG_OWN_ADDR && prdata !== node_addr) ||
            (regsel == rtul_pkg::REG_HYST && prdata[7:0] !== hyst_level))
        begin
            $display("%0t: register 0x%0h readback: expected 0x%0h, actual 0x%0h", $time,
                     {regsel, 3'b000},
                     (regsel == rtul_pkg::REG_OWN_ADDR) ? node_addr : 64'(hyst_level),
                     prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Random requests in bursts, with random gaps between bursts.
    task automatic stream_requests(input int count, input int max_gap, input int max_burst);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, max_burst);
        for (int i = 0; i < count; i++)
        begin
            send_request(make_random_request());
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, max_burst);
                gap = $urandom_range(0, max_gap);
                if (gap > 0)
                begin
                    req_bus.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each reply with the oldest one owed.
    always @(posedge clk)
    begin : reply_check
        route_reply_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (route_replies.size() == 0)
            begin
                $display("%0t: reply with no request pending: expected none, actual status %0d",
                         $time, rsp_bus.status);
                errors++;
            end
            else
            begin
                want = route_replies.pop_front();
                check_field("status", 64'(want.status), 64'(rsp_bus.status));
                check_field("next_hop_addr", want.next_hop_addr, rsp_bus.next_hop_addr);
                check_field("route_hops", 64'(want.route_hops), 64'(rsp_bus.route_hops));
                check_field("route_metric", 64'(want.route_metric),
                            64'($unsigned(rsp_bus.route_metric)));
                check_field("route_seq", 64'(want.route_seq), 64'(rsp_bus.route_seq));
                replies_checked++;
                if (!$isunknown(rsp_bus.status))
                    status_seen[int'(rsp_bus.status)]++;
            end
        end
    end

    // Receiver: a long hold-off when asked, otherwise the repeating stall mask.
    initial
    begin : reply_stall
        int phase;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_off_left--;
            end
            else
            begin
                rsp_bus.ready <= !stall_mask[phase];
                phase = (phase + 1) % 16;
            end
        end
    end

    // Own address is 0 after reset and answers as the implicit self route.
    task automatic test_self_route_at_reset();
        issue_request(rtul_pkg::REQ_LOOKUP, 64'h0, 0, 0, 0);
        issue_request(rtul_pkg::REQ_UPDATE, 64'h0, 3, 10, 1);
        issue_request(rtul_pkg::REQ_LOOKUP, '1, 0, 0, 0);
        settle();
    endtask

    // Inserts with extreme fields, then the sequence and hysteresis rules on a stored route.
    task automatic test_insert_and_lookup();
        write_register(rtul_pkg::REG_OWN_ADDR, 64'hA5A5_5A5A_0F0F_F0F0);
        write_register(rtul_pkg::REG_HYST, 64'(rtul_pkg::HYST_RESET));
        issue_request(rtul_pkg::REQ_UPDATE, '1, 255, 127, 65535);
        issue_request(rtul_pkg::REQ_UPDATE, 64'h1, 0, -128, 0);
        issue_request(rtul_pkg::REQ_UPDATE, 64'h0, 1, 0, 100);
        issue_request(rtul_pkg::REQ_LOOKUP, '1, 0, 0, 0);
        issue_request(rtul_pkg::REQ_LOOKUP, 64'h1, 0, 0, 0);
        // Equal sequence number, large difference: left alone.
        issue_request(rtul_pkg::REQ_UPDATE, 64'h1, 9, 127, 0);
        // Newer report, difference exactly at the hysteresis: left alone.
        issue_request(rtul_pkg::REQ_UPDATE, 64'h1, 9, -123, 1);
        // Newer report, difference one past the hysteresis: metric replaced.
        issue_request(rtul_pkg::REQ_UPDATE, 64'h1, 9, -122, 1);
        issue_request(rtul_pkg::REQ_UPDATE, '1, 9, -128, 65535);
        issue_request(rtul_pkg::REQ_LOOKUP, 64'h1, 0, 0, 0);
        settle();
    endtask

    // Fill the remaining slots, then a new destination finds no room.
    task automatic test_table_full();
        issue_request(rtul_pkg::REQ_UPDATE, 64'h2, 7, -128, 0);
        issue_request(rtul_pkg::REQ_UPDATE, 64'h3, 2, 5, 10);
        issue_request(rtul_pkg::REQ_UPDATE, 64'h4, 128, -1, 32768);
        issue_request(rtul_pkg::REQ_UPDATE, 64'h5555_AAAA_5555_AAAA, 64, 64, 255);
        issue_request(rtul_pkg::REQ_UPDATE, 64'h1234, 1, 1, 1);
        issue_request(rtul_pkg::REQ_LOOKUP, 64'h1234, 0, 0, 0);
        issue_request(rtul_pkg::REQ_UPDATE, node_addr, 1, 1, 1);
        settle();
    endtask

    // A stored route whose address becomes the own address is hidden by the self route.
    task automatic test_own_address_shadowing();
        write_register(rtul_pkg::REG_OWN_ADDR, 64'h1);
        issue_request(rtul_pkg::REQ_LOOKUP, 64'h1, 0, 0, 0);
        issue_request(rtul_pkg::REQ_UPDATE, 64'h1, 3, 100, 60000);
        settle();
    endtask

    // Zero hysteresis replaces on any difference; full-scale hysteresis never replaces.
    task automatic test_hysteresis_extremes();
        write_register(rtul_pkg::REG_HYST, 64'h0);
        issue_request(rtul_pkg::REQ_UPDATE, 64'h0, 1, 0, 101);
        issue_request(rtul_pkg::REQ_UPDATE, 64'h0, 1, 1, 101);
        settle();
        write_register(rtul_pkg::REG_HYST, 64'hFF);
        issue_request(rtul_pkg::REQ_UPDATE, 64'h2, 7, 127, 9);
        settle();
    endtask

    task automatic test_random_traffic(input int count, input logic [63:0] own,
                                       input logic [7:0] hyst, input int max_gap,
                                       input int max_burst, input logic [15:0] mask);
        write_register(rtul_pkg::REG_OWN_ADDR, own);
        write_register(rtul_pkg::REG_HYST, 64'(hyst));
        stall_mask = mask;
        stream_requests(count, max_gap, max_burst);
        settle();
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_reply_backpressure();
        stall_mask = 16'h0;
        hold_off_left = 300;
        stream_requests(200, 0, 1);
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_bus.valid = 1'b0;
        req_bus.req_type = rtul_pkg::REQ_UPDATE;
        req_bus.dest_addr = '0;
        req_bus.report_hops = '0;
        req_bus.link_metric = '0;
        req_bus.report_seq = '0;
        rsp_bus.ready = 1'b0;
        stall_mask = 16'h0;
        hold_off_left = 0;
        errors = 0;
        requests_sent = 0;
        replies_checked = 0;
        node_addr = '0;
        hyst_level = rtul_pkg::HYST_RESET;
        for (int i = 0; i < SLOTS; i++)
            known_used[i] = 1'b0;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_self_route_at_reset();
        test_insert_and_lookup();
        test_table_full();
        test_own_address_shadowing();
        test_hysteresis_extremes();
        test_random_traffic(300, {$urandom, $urandom}, 8'($urandom_range(1, 30)), 6, 8,
                            16'($urandom) & 16'h7FFF);
        test_random_traffic(300, '1, 8'h0, 3, 12, 16'($urandom) & 16'h7FFF);
        test_random_traffic(300, known_dest[$urandom_range(0, SLOTS - 1)], 8'hFF, 6, 4,
                            16'hF7FF);
        test_random_traffic(300, 64'h0, rtul_pkg::HYST_RESET, 0, 1, 16'h0);
        test_reply_backpressure();

        repeat (8) @(posedge clk);
        $display("Covered %0d requests and %0d replies: directed cases, then four register %s",
                 requests_sent, replies_checked, "settings of random traffic.");
        $display("Replies: %0d hit, %0d miss, %0d inserted, %0d updated, %0d unchanged, %s",
                 status_seen[rtul_pkg::ST_HIT], status_seen[rtul_pkg::ST_MISS],
                 status_seen[rtul_pkg::ST_INSERTED], status_seen[rtul_pkg::ST_UPDATED],
                 status_seen[rtul_pkg::ST_UNCHANGED],
                 $sformatf("%0d full, %0d own.", status_seen[rtul_pkg::ST_FULL],
                           status_seen[rtul_pkg::ST_OWN]));
        if (errors == 0 && route_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rtul_pkg.sv
rtl/core/rtul_if.sv
rtl/core/route_table_update_lookup.sv
rtl/core/rtul_checker.sv
tb/tb_route_table_update_lookup.sv
